### rtl/lru_page_replacement_unit_assert.svh
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_assert
// Assertion macros for the LRU page replacement unit.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni in scope.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRU_PR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRU_PR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lru_pr_pkg.sv
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared types and fixed widths of the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  localparam int unsigned CFG_W       = 4;
  localparam int unsigned FAULT_W     = 16;
  localparam int unsigned FRAME_OUT_W = 3;

  // Status of one scan over the frame table
  typedef struct packed {
    logic hit;      // page found in a valid frame
    logic empty;    // empty frame found below the frame count
    logic lru_any;  // valid frame found below the frame count
  } scan_flags_t;

endpackage

### rtl/lru_pr_scan.sv
// ----------------------------------------------------------------------------
// lru_pr_scan
// Shared compare unit: looks at one frame per step and tracks the first
// matching frame, the first empty frame and the least recently used frame.
// ----------------------------------------------------------------------------
module lru_pr_scan #(
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned PAGE_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     step_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic                     in_range_i,
  input  logic                     ent_valid_i,
  input  logic [PAGE_BITS-1:0]     ent_page_i,
  input  logic [IDX_W-1:0]         ent_rank_i,
  input  logic [PAGE_BITS-1:0]     page_i,
  output lru_pr_pkg::scan_flags_t  flags_o,
  output logic [IDX_W-1:0]         hit_idx_o,
  output logic [IDX_W-1:0]         hit_rank_o,
  output logic [IDX_W-1:0]         empty_idx_o,
  output logic [IDX_W-1:0]         lru_idx_o,
  output logic [IDX_W-1:0]         lru_rank_o,
  output logic [PAGE_BITS-1:0]     lru_page_o
);
  import lru_pr_pkg::*;

  scan_flags_t          flags_q;
  logic [IDX_W-1:0]     hit_idx_q, hit_rank_q, empty_idx_q, lru_idx_q, lru_rank_q;
  logic [PAGE_BITS-1:0] lru_page_q;
  logic                 match, take_hit, take_empty, take_lru;

  // The one comparator pair shared by all frames
  assign match      = ent_valid_i && (ent_page_i == page_i);
  assign take_hit   = step_i && match && !flags_q.hit;
  assign take_empty = step_i && in_range_i && !ent_valid_i && !flags_q.empty;
  assign take_lru   = step_i && in_range_i && ent_valid_i &&
                      (!flags_q.lru_any || (ent_rank_i > lru_rank_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (start_i) begin
      flags_q <= '0;
    end else begin
      if (take_hit)   flags_q.hit     <= 1'b1;
      if (take_empty) flags_q.empty   <= 1'b1;
      if (take_lru)   flags_q.lru_any <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q  <= idx_i;
      hit_rank_q <= ent_rank_i;
    end
    if (take_empty) begin
      empty_idx_q <= idx_i;
    end
    if (take_lru) begin
      lru_idx_q  <= idx_i;
      lru_rank_q <= ent_rank_i;
      lru_page_q <= ent_page_i;
    end
  end

  assign flags_o     = flags_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_rank_o  = hit_rank_q;
  assign empty_idx_o = empty_idx_q;
  assign lru_idx_o   = lru_idx_q;
  assign lru_rank_o  = lru_rank_q;
  assign lru_page_o  = lru_page_q;

endmodule

### rtl/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// LRU page replacement over a small frame table, one page reference per word.
// ----------------------------------------------------------------------------
// Each input word is a page reference. After the word is accepted, a single
// shared compare unit walks all FRAMES frames, one per cycle, then the update
// state changes the table and the recency ranks and loads the result register.
// The input stalls from the accepting edge until the update is done and the
// next word can be taken in the cycle after that, so a new word is not taken
// before the previous one has been through its update. A result that still
// waits in the result register holds the update state, and with it the input,
// until it is taken; a new word may be taken while the previous result waits.
// Hits make the frame most recent; a fault fills the lowest empty frame while
// fewer faults than the frame count have occurred, otherwise it replaces the
// least recently used frame below the frame count, or fills frame zero when
// no valid frame lies below it. The fault count saturates at its maximum.
// num_frames of 0 acts as 1 and values above FRAMES act as FRAMES; write it
// only while the block is idle.
module lru_page_replacement_unit #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [lru_pr_pkg::CFG_W-1:0]        cfg_wdata_i,
  // reference words in
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [PAGE_BITS-1:0]                page_i,
  // result words out
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [lru_pr_pkg::FRAME_OUT_W-1:0]  frame_o,
  output logic                                evicted_valid_o,
  output logic [PAGE_BITS-1:0]                evicted_page_o,
  output logic [lru_pr_pkg::FAULT_W-1:0]      fault_count_o
);
  import lru_pr_pkg::*;

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned NW    = $clog2(FRAMES + 1);
  localparam int unsigned CW    = (NW > CFG_W) ? NW : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Frame table: pages carry no reset, valid bits and ranks do
  logic [PAGE_BITS-1:0] page_tab_q [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [IDX_W-1:0]     rank_q [FRAMES];

  logic [CFG_W-1:0]     num_frames_q;
  logic [FAULT_W-1:0]   faults_q, faults_nxt;
  logic [PAGE_BITS-1:0] req_page_q;
  logic [IDX_W-1:0]     cnt_q;

  logic                 in_accept, out_free, scan_step, scan_last, upd_fire;
  logic [CW-1:0]        num_ext;
  logic [NW-1:0]        n_eff;
  logic                 in_range;

  scan_flags_t          flags;
  logic [IDX_W-1:0]     hit_idx, hit_rank, empty_idx, lru_idx, lru_rank;
  logic [PAGE_BITS-1:0] lru_page;

  logic [IDX_W-1:0]     sel_idx, sel_old_rank;
  logic                 sel_new, sel_wr_page, sel_ev;

  logic                 out_valid_q, hit_q, ev_valid_q;
  logic [IDX_W-1:0]     frame_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic [FAULT_W-1:0]   fault_out_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign scan_step  = (state_q == ST_SCAN);
  assign scan_last  = (cnt_q == IDX_W'(FRAMES - 1));
  assign upd_fire   = (state_q == ST_UPDATE) && out_free;

  // Clamp the frame count into 1..FRAMES
  assign num_ext = CW'(num_frames_q);
  always_comb begin
    if (num_ext == '0) begin
      n_eff = NW'(1);
    end else if (num_ext > CW'(FRAMES)) begin
      n_eff = NW'(FRAMES);
    end else begin
      n_eff = NW'(num_ext);
    end
  end

  assign in_range = (NW'(cnt_q) < n_eff);

  // Sequencer: idle, walk every frame, then the update state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_UPDATE;
      ST_UPDATE: if (out_free)  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      num_frames_q <= CFG_W'(8);
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        cnt_q <= '0;
      end else if (scan_step) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (cfg_we_i) num_frames_q <= cfg_wdata_i;
    end
  end

  // Latch the referenced page for the whole walk
  always_ff @(posedge clk_i) begin
    if (in_accept) req_page_q <= page_i;
  end

  lru_pr_scan #(
    .IDX_W     (IDX_W),
    .PAGE_BITS (PAGE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .step_i      (scan_step),
    .idx_i       (cnt_q),
    .in_range_i  (in_range),
    .ent_valid_i (valid_q[cnt_q]),
    .ent_page_i  (page_tab_q[cnt_q]),
    .ent_rank_i  (rank_q[cnt_q]),
    .page_i      (req_page_q),
    .flags_o     (flags),
    .hit_idx_o   (hit_idx),
    .hit_rank_o  (hit_rank),
    .empty_idx_o (empty_idx),
    .lru_idx_o   (lru_idx),
    .lru_rank_o  (lru_rank),
    .lru_page_o  (lru_page)
  );

  // Pick the frame: hit, else fill while faults stay below the frame count,
  // else replace the LRU frame, else fill frame zero when none is in range
  always_comb begin
    sel_idx      = '0;
    sel_old_rank = '0;
    sel_new      = 1'b1;
    sel_wr_page  = 1'b1;
    sel_ev       = 1'b0;
    if (flags.hit) begin
      sel_idx      = hit_idx;
      sel_old_rank = hit_rank;
      sel_new      = 1'b0;
      sel_wr_page  = 1'b0;
    end else if ((faults_q < FAULT_W'(n_eff)) && flags.empty) begin
      sel_idx = empty_idx;
    end else if (flags.lru_any) begin
      sel_idx      = lru_idx;
      sel_old_rank = lru_rank;
      sel_new      = 1'b0;
      sel_ev       = 1'b1;
    end
  end

  assign faults_nxt = (!flags.hit && (faults_q != '1)) ? faults_q + FAULT_W'(1) : faults_q;

  // Table and rank update: age every valid frame more recent than the chosen
  // one (every valid frame when it is newly filled), then make it most recent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      faults_q <= '0;
      for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
    end else if (upd_fire) begin
      faults_q <= faults_nxt;
      for (int i = 0; i < FRAMES; i++) begin
        if (IDX_W'(i) == sel_idx) begin
          rank_q[i]  <= '0;
          valid_q[i] <= 1'b1;
        end else if (valid_q[i] && (sel_new || (rank_q[i] < sel_old_rank))) begin
          rank_q[i] <= rank_q[i] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire && sel_wr_page) page_tab_q[sel_idx] <= req_page_q;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      hit_q       <= flags.hit;
      frame_q     <= sel_idx;
      ev_valid_q  <= sel_ev;
      ev_page_q   <= sel_ev ? lru_page : '0;
      fault_out_q <= faults_nxt;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_o         = FRAME_OUT_W'(frame_q);
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;

  `include "lru_page_replacement_unit_assert.svh"

  `LRU_PR_ASSERT_NEXT(a_walk_start, in_accept, state_q == ST_SCAN && cnt_q == '0, "bad walk start")
  `LRU_PR_ASSERT_NOW(a_result_src, $rose(out_valid_o), $past(state_q == ST_UPDATE), "no update")
  `LRU_PR_ASSERT_NEXT(a_faults_mono, 1'b1, faults_q >= $past(faults_q), "fault count went back")
  `LRU_PR_ASSERT_NOW(a_fault_cnt, out_valid_o && !hit_o, fault_count_o != '0, "fault not counted")

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU page replacement unit.
// ----------------------------------------------------------------------------
// Page references go in through a valid/stall channel. Each accepted word
// runs through a local model of the frame table, and the expected result is
// queued. Every result word taken from the block is checked field by field
// against the oldest queued result. Directed tests cover the frame count
// special cases. Random phases follow under three idle patterns, with a long
// receiver hold-off and a short thrashing run where nearly every reference
// faults.
module testbench;

  localparam int unsigned LRU_FRAMES = 8;
  localparam int unsigned PAGE_W     = 8;

  // One expected result word
  typedef struct packed {
    logic                                  hit;
    logic [lru_pr_pkg::FRAME_OUT_W-1:0]    frame;
    logic                                  ev_vld;
    logic [PAGE_W-1:0]                     ev_page;
    logic [lru_pr_pkg::FAULT_W-1:0]        faults;
  } lru_result_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [lru_pr_pkg::CFG_W-1:0]         cfg_wdata_i;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [PAGE_W-1:0]                    page_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic                                 hit_o;
  logic [lru_pr_pkg::FRAME_OUT_W-1:0]   frame_o;
  logic                                 evicted_valid_o;
  logic [PAGE_W-1:0]                    evicted_page_o;
  logic [lru_pr_pkg::FAULT_W-1:0]       fault_count_o;

  // Local copy of the frame table and the frame count register
  logic [PAGE_W-1:0]             frm_page [LRU_FRAMES];
  bit                            frm_vld  [LRU_FRAMES];
  int                            frm_rank [LRU_FRAMES];
  int unsigned                   flt_total;
  logic [lru_pr_pkg::CFG_W-1:0]  nf_reg;

  lru_result_t pending_results [$];
  int          err_cnt;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          hold_left;

  lru_page_replacement_unit #(
    .FRAMES    (LRU_FRAMES),
    .PAGE_BITS (PAGE_W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .page_i          (page_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_o         (frame_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Frame table model
  // --------------------------------------------------------------------------

  // Make frame f the most recent one. Every valid frame that was more recent
  // than f ages by one; pass LRU_FRAMES as old_rank for a freshly filled frame.
  function automatic void promote_frame(input int f, input int old_rank);
    for (int i = 0; i < LRU_FRAMES; i++) begin
      if (i != f && frm_vld[i] && frm_rank[i] < old_rank) frm_rank[i]++;
    end
    frm_rank[f] = 0;
  endfunction

  // Apply one page reference to the table and return the result word.
  function automatic lru_result_t lookup_page(input logic [PAGE_W-1:0] pg);
    lru_result_t res;
    int          n;
    int          f;
    int          best;
    bit          found;
    bit          placed;
    bit          any;
    res    = '0;
    f      = 0;
    best   = 0;
    found  = 1'b0;
    placed = 1'b0;
    any    = 1'b0;
    // zero acts as one, anything above the table size as the table size
    n = (nf_reg == 0) ? 1 : ((nf_reg > LRU_FRAMES) ? LRU_FRAMES : int'(nf_reg));

    // hits are found in every valid frame, even above the frame count
    for (int i = 0; i < LRU_FRAMES; i++) begin
      if (!found && frm_vld[i] && frm_page[i] == pg) begin
        f     = i;
        found = 1'b1;
      end
    end

    if (found) begin
      promote_frame(f, frm_rank[f]);
    end else begin
      // fill the lowest empty frame only while faults are below the count
      if (flt_total < n) begin
        for (int i = 0; i < n; i++) begin
          if (!placed && !frm_vld[i]) begin
            f      = i;
            placed = 1'b1;
          end
        end
      end
      if (placed) begin
        frm_vld[f]  = 1'b1;
        frm_page[f] = pg;
        promote_frame(f, LRU_FRAMES);
      end else begin
        // pick the least recently used valid frame below the count
        for (int i = 0; i < n; i++) begin
          if (frm_vld[i] && (!any || frm_rank[i] > best)) begin
            best = frm_rank[i];
            f    = i;
            any  = 1'b1;
          end
        end
        if (any) begin
          res.ev_vld  = 1'b1;
          res.ev_page = frm_page[f];
          frm_page[f] = pg;
          promote_frame(f, frm_rank[f]);
        end else begin
          f           = 0;
          frm_vld[0]  = 1'b1;
          frm_page[0] = pg;
          promote_frame(0, LRU_FRAMES);
        end
      end
      if (flt_total < 16'hFFFF) flt_total++;
    end

    res.hit    = found;
    res.frame  = 3'(f);
    res.faults = 16'(flt_total);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted reference, check every result word
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon_blk
    lru_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) nf_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) pending_results.push_back(lookup_page(page_i));
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with no reference pending");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit",           16'(want.hit),     16'(hit_o));
          check_field("frame",         16'(want.frame),   16'(frame_o));
          check_field("evicted_valid", 16'(want.ev_vld),  16'(evicted_valid_o));
          check_field("evicted_page",  16'(want.ev_page), 16'(evicted_page_o));
          check_field("fault_count",   want.faults,       fault_count_o);
        end
      end
    end
  end

  // Receiver: stall at random, or hold off for a counted stretch on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Shared driver tasks; each returns at a rising edge
  // --------------------------------------------------------------------------

  // Offer one reference word; hold it until the block takes it.
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    page_i     <= pg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected result word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the frame count; call only once the block is idle.
  task automatic write_frames(input logic [lru_pr_pkg::CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill one frame with a count of one, then raise the count: the next fault
  // still fills an empty frame since faults are below the new count.
  task automatic test_raise_after_fill();
    write_frames(4'd1);
    send_page(8'h00);
    send_page(8'h00);
    drain_results();
    write_frames(4'd8);
    send_page(8'hFF);
  endtask

  // Fill the remaining frames, hit two of them, then force an eviction.
  task automatic test_fill_and_hit();
    send_page(8'h55);
    send_page(8'hAA);
    send_page(8'h01);
    send_page(8'h02);
    send_page(8'h03);
    send_page(8'h04);
    send_page(8'hFF);
    send_page(8'h00);
    send_page(8'h09);
  endtask

  // Lowered count: a page in a high frame still hits; the fault replaces a frame below the count.
  task automatic test_count_lowered();
    drain_results();
    write_frames(4'd3);
    send_page(8'h04);
    send_page(8'h10);
  endtask

  // Count of zero behaves as one: every fault replaces frame zero.
  task automatic test_count_zero();
    drain_results();
    write_frames(4'd0);
    send_page(8'h11);
    send_page(8'h12);
  endtask

  // Count above the table size behaves as the full table.
  task automatic test_count_large();
    drain_results();
    write_frames(4'd15);
    send_page(8'h13);
    send_page(8'h14);
  endtask

  // Mostly references into a small working set around a drifting base, so
  // hits and evictions both happen; the rest spread over every page number.
  task automatic test_random_phase(input logic [lru_pr_pkg::CFG_W-1:0] frames,
                                   input int count);
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] pg;
    int                span;
    drain_results();
    write_frames(frames);
    base = PAGE_W'($urandom);
    span = ((frames == 0) ? 1 : ((frames > LRU_FRAMES) ? LRU_FRAMES : frames))
           + $urandom_range(3);
    repeat (count) begin
      if ($urandom_range(49) == 0) base = PAGE_W'($urandom);
      if ($urandom_range(9) < 7) pg = base + PAGE_W'($urandom_range(span));
      else                       pg = PAGE_W'($urandom);
      send_page(pg);
    end
  endtask

  // Hold off the receiver for a long stretch while words keep coming, so the
  // result register fills and the block stalls its input.
  task automatic test_receiver_hold();
    @(negedge clk_i);
    hold_left = 300;
    @(posedge clk_i);
    repeat (10) send_page(PAGE_W'($urandom));
    while (hold_left != 0) @(posedge clk_i);
    drain_results();
  endtask

  // Cycle nine pages through eight frames: once the table settles, every
  // reference evicts the least recently used page.
  task automatic test_fault_thrash();
    drain_results();
    write_frames(4'd8);
    for (int k = 0; k < 54; k++) send_page(PAGE_W'(8'hE0 + k % 9));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    page_i       = '0;
    out_stall_i  = 1'b0;
    hold_left    = 0;
    err_cnt      = 0;
    flt_total    = 0;
    nf_reg       = 4'd8;
    foreach (frm_vld[i]) begin
      frm_vld[i]  = 1'b0;
      frm_rank[i] = 0;
      frm_page[i] = '0;
    end
    // sender idles often, receiver stalls more
    snd_idle_pct = 35;
    rcv_idle_pct = 64;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_raise_after_fill();
    test_fill_and_hit();
    test_count_lowered();
    test_count_zero();
    test_count_large();

    test_random_phase(4'd8, 80);
    test_random_phase(4'd1, 80);
    test_receiver_hold();
    test_random_phase(4'd3, 80);
    test_random_phase(4'd15, 80);

    // swap the idle patterns
    snd_idle_pct = 64;
    rcv_idle_pct = 35;
    test_random_phase(4'd0, 80);
    test_random_phase(4'd5, 80);
    test_random_phase(4'd9, 80);
    test_random_phase(4'd7, 80);

    // no idling at all
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_phase(4'd2, 80);
    test_random_phase(4'd6, 80);
    test_random_phase(4'd8, 80);
    test_fault_thrash();
    test_random_phase(4'd1, 80);
    test_random_phase(4'd4, 80);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
